// File: hdl/idle_timeout_frame_receiver_unit_assert.svh
// Assertion helpers used by the receiver control block.
`ifndef IDLE_TIMEOUT_FRAME_RECEIVER_UNIT_ASSERT_SVH
`define IDLE_TIMEOUT_FRAME_RECEIVER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ITFR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("itfr check failed");

// Next-cycle implication, checked outside reset.
`define ITFR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("itfr check failed");

`endif

// File: hdl/itfr_pkg.sv
package itfr_pkg;

  // Default frame buffer depth in bytes
  localparam int DEF_BUF_DEPTH = 256;

  // Gap used when the timeout register holds zero
  localparam logic [15:0] DEFAULT_GAP_MS = 16'd10;

  // Field widths
  localparam int LEN_W  = 9;
  localparam int BYTE_W = 8;
  localparam int TIME_W = 32;
  localparam int GAP_W  = 16;

  // Operation selector carried on tuser
  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_POLL  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } itfr_op_t;

  // Configuration register indexes
  localparam logic REG_FIXED_LEN = 1'b0;
  localparam logic REG_GAP       = 1'b1;

  // Frame status as seen on the result side
  typedef struct packed {
    logic             ready;
    logic [LEN_W-1:0] length;
    logic [LEN_W-1:0] fill;
  } itfr_status_t;

endpackage

// File: hdl/idle_timeout_frame_receiver_unit.sv
// Frame receiver: bytes go into a buffer RAM; frames close on fixed length or idle gap.
// A result passes stage one, then the output register. The buffer RAM has one write and
// one read port. Throughput: one transfer per cycle while results are taken.
// Reset: rst clears position, timestamp, ready flags, length and config; the buffer
// RAM is not cleared and needs no clearing pass.
module idle_timeout_frame_receiver_unit import itfr_pkg::*; #(
  parameter int BUF_DEPTH = DEF_BUF_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  // Configuration
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [GAP_W-1:0]  cfg_wdata,
  // Input stream
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [47:0]       s_tdata,   // rx_data[7:0], now_ms[39:8], read_index[47:40]
  input  logic [1:0]        s_tuser,   // operation[1:0]
  // Result stream
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [31:0]       m_tdata    // frame_ready[0], frame_length[9:1],
                                       // fill_count[18:10], read_data[26:19], zeros
);

  localparam int AW = $clog2(BUF_DEPTH);
  localparam int PW = $clog2(BUF_DEPTH + 1);
  localparam int CW = (PW > LEN_W) ? PW : LEN_W;

  logic              accept, s1_valid, s1_rd, s1_adv, rd_req;
  itfr_op_t          op;
  logic [BYTE_W-1:0] rx_data, read_index, rd_byte, ram_rdata, ram_wdata;
  logic [TIME_W-1:0] now_ms;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  itfr_status_t      status;

  // Input unpack
  assign op         = itfr_op_t'(s_tuser);
  assign rx_data    = s_tdata[7:0];
  assign now_ms     = s_tdata[39:8];
  assign read_index = s_tdata[47:40];

  // Handshake: stage one moves on when the output register is free
  assign s1_adv   = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || s1_adv;
  assign accept   = s_tvalid && s_tready;
  assign rd_req   = accept && (op == OP_READ) && (CW'(read_index) < CW'(BUF_DEPTH));

  itfr_ctrl #(.BUF_DEPTH(BUF_DEPTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .op        (op),
    .rx_data   (rx_data),
    .now_ms    (now_ms),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .status    (status)
  );

  itfr_ram #(.WIDTH(BYTE_W), .DEPTH(BUF_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (rd_req),
    .raddr (AW'(read_index)),
    .rdata (ram_rdata)
  );

  // Stage one: waits for read data; state registers already hold the result
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_rd <= rd_req;
    end
  end

  assign rd_byte = s1_rd ? ram_rdata : '0;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      m_tdata <= {5'b0, rd_byte, status.fill, status.length, status.ready};
    end
  end

endmodule

// File: hdl/itfr_ram.sv
module itfr_ram import itfr_pkg::*; #(
  parameter int WIDTH = BYTE_W,
  parameter int DEPTH = DEF_BUF_DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port; rdata holds when re is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/itfr_ctrl.sv
module itfr_ctrl import itfr_pkg::*; #(
  parameter int BUF_DEPTH = DEF_BUF_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [GAP_W-1:0]             cfg_wdata,
  input  logic                         accept,
  input  itfr_op_t                     op,
  input  logic [BYTE_W-1:0]            rx_data,
  input  logic [TIME_W-1:0]            now_ms,
  output logic                         ram_we,
  output logic [$clog2(BUF_DEPTH)-1:0] ram_waddr,
  output logic [BYTE_W-1:0]            ram_wdata,
  output itfr_status_t                 status
);

  `include "idle_timeout_frame_receiver_unit_assert.svh"

  localparam int AW = $clog2(BUF_DEPTH);
  localparam int PW = $clog2(BUF_DEPTH + 1);
  localparam int CW = (PW > LEN_W) ? PW : LEN_W;

  // Configuration registers
  logic [BYTE_W-1:0] fixed_length;
  logic [GAP_W-1:0]  gap_timeout;

  // Frame state
  logic [PW-1:0]     write_pos, write_pos_next;
  logic [TIME_W-1:0] last_byte_time, last_byte_time_next;
  logic              ready_flag, ready_flag_next;
  logic              ready_flag_prev, ready_flag_prev_next;
  logic [CW-1:0]     done_length, done_length_next;

  logic              is_byte, is_poll, restart, timed_out, store;
  logic [PW-1:0]     pos_base, pos_gap, pos_stored;
  logic [TIME_W-1:0] elapsed;
  logic [GAP_W-1:0]  gap;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      fixed_length <= '0;
      gap_timeout  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FIXED_LEN: fixed_length <= cfg_wdata[BYTE_W-1:0];
        REG_GAP:       gap_timeout  <= cfg_wdata;
        default:       ;
      endcase
    end
  end

  // Next-state logic: restart, gap check, buffer write, fixed-length close, clear
  always_comb begin
    is_byte  = accept && (op == OP_BYTE);
    is_poll  = accept && (op == OP_POLL);
    restart  = is_byte && ready_flag_prev && !ready_flag;
    pos_base = restart ? '0 : write_pos;
    gap      = (gap_timeout != '0) ? gap_timeout : DEFAULT_GAP_MS;
    elapsed  = now_ms - last_byte_time;
    timed_out = (is_byte || is_poll) && (pos_base != '0) &&
                (elapsed >= TIME_W'(gap));

    write_pos_next       = write_pos;
    last_byte_time_next  = last_byte_time;
    ready_flag_next      = ready_flag;
    ready_flag_prev_next = is_byte ? ready_flag : ready_flag_prev;
    done_length_next     = done_length;

    // Idle gap closes the frame unless the flag is still up; the position always rewinds
    if (timed_out && !ready_flag) begin
      done_length_next     = CW'(pos_base);
      ready_flag_next      = 1'b1;
      ready_flag_prev_next = 1'b1;
    end
    pos_gap = timed_out ? '0 : pos_base;

    // Store when the buffer has room
    store      = is_byte && (pos_gap < PW'(BUF_DEPTH));
    pos_stored = store ? pos_gap + PW'(1) : pos_gap;

    if (is_poll) begin
      write_pos_next = pos_gap;
    end
    if (is_byte) begin
      write_pos_next      = pos_stored;
      last_byte_time_next = now_ms;
      if (fixed_length != '0 && CW'(pos_stored) >= CW'(fixed_length)) begin
        done_length_next     = CW'(fixed_length);
        ready_flag_next      = 1'b1;
        ready_flag_prev_next = 1'b1;
      end
    end
    if (accept && op == OP_CLEAR) begin
      ready_flag_next = 1'b0;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      write_pos       <= '0;
      last_byte_time  <= '0;
      ready_flag      <= 1'b0;
      ready_flag_prev <= 1'b0;
      done_length     <= '0;
    end else begin
      write_pos       <= write_pos_next;
      last_byte_time  <= last_byte_time_next;
      ready_flag      <= ready_flag_next;
      ready_flag_prev <= ready_flag_prev_next;
      done_length     <= done_length_next;
    end
  end

  // Buffer write request
  assign ram_we    = store;
  assign ram_waddr = pos_gap[AW-1:0];
  assign ram_wdata = rx_data;

  // Status after the last accepted transfer
  assign status.ready  = ready_flag;
  assign status.length = done_length[LEN_W-1:0];
  assign status.fill   = LEN_W'(write_pos);

  `ITFR_ASSERT_NOW(a_pos_bound, 1'b1, write_pos <= PW'(BUF_DEPTH))
  `ITFR_ASSERT_NOW(a_write_src, ram_we, accept && op == OP_BYTE)
  `ITFR_ASSERT_NEXT(a_clear, accept && op == OP_CLEAR, !ready_flag)
  `ITFR_ASSERT_NOW(a_len_set, $rose(ready_flag), done_length != '0)

endmodule

// File: tb/sv/tb_idle_timeout_frame_receiver_unit.sv
`timescale 1ns / 100ps

module tb_idle_timeout_frame_receiver_unit;
  import itfr_pkg::*;

  localparam int STORE_DEPTH = DEF_BUF_DEPTH;
  localparam int ITEM_TARGET = 1300;
  localparam int CYCLE_LIMIT = 600000;

  // One input transfer: operation plus its operands
  typedef struct packed {
    itfr_op_t    op;
    logic [7:0]  data;
    logic [31:0] now;
    logic [7:0]  idx;
  } rx_item_t;

  // One result transfer, unpacked from m_tdata
  typedef struct packed {
    logic       ready;
    logic [8:0] length;
    logic [8:0] fill;
    logic [7:0] rdata;
  } rx_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic              cfg_index = 1'b0;
  logic [GAP_W-1:0]  cfg_wdata = '0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [47:0]       s_tdata = '0;   // rx_data[7:0], now_ms[39:8], read_index[47:40]
  logic [1:0]        s_tuser = '0;   // operation[1:0]
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [31:0]       m_tdata;        // frame_ready[0], frame_length[9:1],
                                     // fill_count[18:10], read_data[26:19], zeros

  idle_timeout_frame_receiver_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always #5 clk = ~clk;

  // Stimulus and result bookkeeping
  rx_item_t   pending_items[$];
  rx_result_t frame_status_q[$];
  int         items_queued = 0;
  int         results_seen = 0;
  int         mismatches = 0;
  int         cycle_cnt = 0;
  logic       in_taken = 1'b0;
  int         src_odds = 0;
  int         snk_odds = 0;
  int         src_wait = 0;
  int         snk_wait = 0;

  // Predicted receiver state
  logic [7:0]  rx_store [STORE_DEPTH];
  logic [8:0]  rx_pos;
  logic [31:0] rx_last_ms;
  logic        rx_ready;
  logic        rx_ready_prev;
  logic [8:0]  rx_done_len;
  logic [7:0]  reg_fixed_len;
  logic [15:0] reg_gap_ms;
  int          rx_high;      // entries below this index have been written

  // Stimulus-side view of the configuration and the time line
  logic [7:0]  cur_fixed = '0;
  logic [15:0] cur_gap = '0;
  logic [31:0] t_ms = '0;

  // Idle gap check: closes the frame, or drops it while the flag is still up
  function automatic void close_on_gap(input logic [31:0] now_ms);
    logic [31:0] limit_ms;
    logic [31:0] elapsed;
    limit_ms = (reg_gap_ms == '0) ? 32'(DEFAULT_GAP_MS) : 32'(reg_gap_ms);
    elapsed = now_ms - rx_last_ms;
    if (rx_pos != '0 && elapsed >= limit_ms) begin
      if (!rx_ready) begin
        rx_done_len = rx_pos;
        rx_ready = 1'b1;
        rx_ready_prev = 1'b1;
      end
      rx_pos = '0;
    end
  endfunction

  // Advance the predicted state by one transfer and return the status it shows
  function automatic rx_result_t frame_rx_apply(input rx_item_t it);
    rx_result_t r;
    r.rdata = '0;
    case (it.op)
      OP_BYTE: begin
        // software cleared the flag: next byte starts over
        if (rx_ready_prev && !rx_ready) rx_pos = '0;
        rx_ready_prev = rx_ready;
        close_on_gap(it.now);
        if (rx_pos < STORE_DEPTH) begin
          rx_store[rx_pos] = it.data;
          rx_pos = rx_pos + 9'd1;
          if (int'(rx_pos) > rx_high) rx_high = int'(rx_pos);
        end
        rx_last_ms = it.now;
        if (reg_fixed_len != '0 && rx_pos >= {1'b0, reg_fixed_len}) begin
          rx_done_len = {1'b0, reg_fixed_len};
          rx_ready = 1'b1;
          rx_ready_prev = 1'b1;
        end
      end
      OP_POLL: close_on_gap(it.now);
      OP_CLEAR: rx_ready = 1'b0;
      default: r.rdata = rx_store[it.idx];
    endcase
    r.ready = rx_ready;
    r.length = rx_done_len;
    r.fill = rx_pos;
    return r;
  endfunction

  // Sample both streams and the config port at the rising edge
  always @(posedge clk) begin : scoreboard
    rx_item_t   acc;
    rx_result_t got;
    rx_result_t want;
    if (rst) begin
      rx_pos = '0;
      rx_last_ms = '0;
      rx_ready = 1'b0;
      rx_ready_prev = 1'b0;
      rx_done_len = '0;
      reg_fixed_len = '0;
      reg_gap_ms = '0;
      rx_high = 0;
      in_taken = 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_FIXED_LEN) reg_fixed_len = cfg_wdata[7:0];
        else reg_gap_ms = cfg_wdata;
      end
      in_taken = s_tvalid && s_tready;
      if (in_taken) begin
        acc.op = itfr_op_t'(s_tuser);
        acc.data = s_tdata[7:0];
        acc.now = s_tdata[39:8];
        acc.idx = s_tdata[47:40];
        frame_status_q.push_back(frame_rx_apply(acc));
      end
      if (m_tvalid && m_tready) begin
        results_seen++;
        got.ready = m_tdata[0];
        got.length = m_tdata[9:1];
        got.fill = m_tdata[18:10];
        got.rdata = m_tdata[26:19];
        if (frame_status_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result with nothing pending: ready=%0d len=%0d fill=%0d rd=%02h",
                     got.ready, got.length, got.fill, got.rdata);
        end else begin
          want = frame_status_q.pop_front();
          if (got.ready !== want.ready || got.length !== want.length ||
              got.fill !== want.fill || got.rdata !== want.rdata) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch #%0d: exp ready=%0d len=%0d fill=%0d rd=%02h, %s",
                       results_seen, want.ready, want.length, want.fill, want.rdata,
                       $sformatf("got ready=%0d len=%0d fill=%0d rd=%02h",
                                 got.ready, got.length, got.fill, got.rdata));
          end
        end
      end
    end
  end

  // Input driver: holds each transfer until taken, with random idle bursts
  always @(negedge clk) begin : src_drive
    rx_item_t nxt;
    if (!rst && !(s_tvalid && !in_taken)) begin
      if (src_wait > 0) begin
        src_wait--;
        s_tvalid <= 1'b0;
      end else if (pending_items.size() == 0) begin
        s_tvalid <= 1'b0;
      end else if (src_odds != 0 && $urandom_range(0, src_odds) == 0) begin
        src_wait = $urandom_range(0, 9);
        s_tvalid <= 1'b0;
      end else begin
        nxt = pending_items.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= {nxt.idx, nxt.now, nxt.data};
        s_tuser <= nxt.op;
      end
    end
  end

  // Result side backpressure
  always @(negedge clk) begin : sink_drive
    if (snk_wait > 0) begin
      snk_wait--;
      m_tready <= 1'b0;
    end else if (snk_odds != 0 && $urandom_range(0, snk_odds) == 0) begin
      snk_wait = $urandom_range(0, 9);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[idle_timeout_frame_receiver_unit] ERROR");
      $finish;
    end
  end

  task automatic send(input itfr_op_t op, input logic [7:0] data,
                      input logic [31:0] now, input logic [7:0] idx);
    pending_items.push_back('{op: op, data: data, now: now, idx: idx});
    items_queued++;
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every queued transfer has come back, then let the pipe settle
  task automatic wait_idle();
    while (results_seen < items_queued) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [31:0] eff_gap();
    return (cur_gap == '0) ? 32'(DEFAULT_GAP_MS) : 32'(cur_gap);
  endfunction

  // Well-formed frame: bytes inside the gap, close by poll, some reads, usually a clear
  task automatic gen_frame(input int hi);
    int n;
    logic [31:0] g;
    g = eff_gap();
    if (cur_fixed != '0 && $urandom_range(0, 3) == 0)
      n = int'(cur_fixed) + $urandom_range(0, 2);
    else
      n = $urandom_range(1, 12);
    for (int k = 0; k < n; k++) begin
      if (k > 0) t_ms += $urandom_range(0, g - 1);
      send(OP_BYTE, 8'($urandom), t_ms, 8'($urandom));
    end
    // near miss one ms short of the gap
    if ($urandom_range(0, 1) == 0)
      send(OP_POLL, 8'($urandom), t_ms + g - 1, 8'($urandom));
    t_ms += g + (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 5));
    send(OP_POLL, 8'($urandom), t_ms, 8'($urandom));
    if (hi > 0)
      repeat ($urandom_range(0, 3))
        send(OP_READ, 8'($urandom), $urandom, 8'($urandom_range(0, hi - 1)));
    // sometimes leave the flag up so the next frame gets dropped
    if ($urandom_range(0, 4) != 0) send(OP_CLEAR, 8'($urandom), $urandom, 8'($urandom));
    t_ms += $urandom_range(0, 3);
  endtask

  // Unordered operations with loose timestamps
  task automatic gen_noise(input int n, input int hi);
    itfr_op_t op;
    logic [31:0] now;
    logic [31:0] g;
    g = eff_gap();
    repeat (n) begin
      op = itfr_op_t'($urandom_range(0, 3));
      if (op == OP_READ && hi == 0) op = OP_POLL;
      now = ($urandom_range(0, 3) == 0) ? $urandom : t_ms + $urandom_range(0, 2 * g);
      if (op == OP_BYTE) t_ms = now;
      send(op, 8'($urandom), now,
           (op == OP_READ) ? 8'($urandom_range(0, hi - 1)) : 8'($urandom));
    end
  endtask

  initial begin : stimulus
    int phase_no;
    int start_cnt;
    int hi;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (3) @(negedge clk);
    src_odds = 3;
    snk_odds = 3;

    // Directed: default 10 ms gap, exact boundary, lost frame, restart, wrap
    send(OP_POLL, 8'h00, 32'd5, 8'h00);
    send(OP_BYTE, 8'h00, 32'd0, 8'h00);
    send(OP_BYTE, 8'hFF, 32'd9, 8'hFF);
    send(OP_BYTE, 8'hA5, 32'd18, 8'h00);
    send(OP_POLL, 8'h00, 32'd27, 8'h00);
    send(OP_POLL, 8'h00, 32'd28, 8'h00);
    send(OP_BYTE, 8'h3C, 32'd30, 8'h00);
    send(OP_POLL, 8'h00, 32'd40, 8'h00);
    send(OP_BYTE, 8'h5A, 32'd41, 8'h00);
    send(OP_BYTE, 8'h96, 32'd60, 8'h00);
    send(OP_CLEAR, 8'hFF, 32'hFFFF_FFFF, 8'hFF);
    send(OP_BYTE, 8'hC3, 32'd61, 8'h00);
    send(OP_BYTE, 8'h81, 32'hFFFF_FFF0, 8'h00);
    send(OP_CLEAR, 8'h00, 32'h0, 8'h00);
    send(OP_BYTE, 8'h7E, 32'hFFFF_FFFA, 8'h00);
    send(OP_BYTE, 8'h18, 32'd2, 8'h00);
    send(OP_POLL, 8'h00, 32'd3, 8'h00);
    send(OP_POLL, 8'h00, 32'd4, 8'h00);
    wait_idle();
    hi = rx_high;
    for (int i = 0; i < 3 && i < hi; i++) send(OP_READ, 8'h00, 32'h0, 8'(i));
    wait_idle();

    // Directed: fixed length of two, repeat past it, restart after clear
    write_reg(REG_FIXED_LEN, 16'd2);
    cur_fixed = 8'd2;
    send(OP_BYTE, 8'h11, 32'd100, 8'h00);
    send(OP_BYTE, 8'h22, 32'd101, 8'h00);
    send(OP_BYTE, 8'h33, 32'd102, 8'h00);
    send(OP_CLEAR, 8'h00, 32'd0, 8'h00);
    send(OP_BYTE, 8'h44, 32'd103, 8'h00);
    send(OP_BYTE, 8'h55, 32'd104, 8'h00);
    wait_idle();
    t_ms = 32'd200;

    // Random phases, each under its own configuration
    phase_no = 0;
    while (items_queued < ITEM_TARGET) begin
      if (items_queued > ITEM_TARGET - 250) begin
        src_odds = 0;
        snk_odds = 0;
      end else begin
        src_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
        snk_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
      end
      if (phase_no == 0) begin
        cur_fixed = 8'd0;
        cur_gap = 16'hFFFF;
      end else begin
        case ($urandom_range(0, 7))
          0: cur_fixed = 8'd1;
          1: cur_fixed = 8'd255;
          2, 3, 4: cur_fixed = 8'd0;
          default: cur_fixed = 8'($urandom_range(2, 16));
        endcase
        case ($urandom_range(0, 5))
          0: cur_gap = 16'd0;
          1: cur_gap = 16'd1;
          2: cur_gap = 16'hFFFF;
          default: cur_gap = 16'($urandom_range(2, 40));
        endcase
      end
      write_reg(REG_FIXED_LEN, {8'h00, cur_fixed});
      write_reg(REG_GAP, cur_gap);
      if ($urandom_range(0, 2) == 0) t_ms = 32'hFFFF_FFFF - $urandom_range(0, 200);
      hi = rx_high;
      if (phase_no == 0) begin
        // overrun the buffer: bytes past the end are dropped
        repeat (STORE_DEPTH + 2) begin
          t_ms += $urandom_range(0, 3);
          send(OP_BYTE, 8'($urandom), t_ms, 8'($urandom));
        end
        t_ms += eff_gap();
        send(OP_POLL, 8'($urandom), t_ms, 8'($urandom));
        send(OP_CLEAR, 8'($urandom), $urandom, 8'($urandom));
      end else begin
        start_cnt = items_queued;
        while (items_queued - start_cnt < 50) begin
          if ($urandom_range(0, 4) != 0) gen_frame(hi);
          else gen_noise($urandom_range(1, 6), hi);
        end
      end
      wait_idle();
      phase_no++;
    end

    repeat (6) @(negedge clk);
    if (mismatches == 0 && frame_status_q.size() == 0)
      $display("[idle_timeout_frame_receiver_unit] OK");
    else
      $display("[idle_timeout_frame_receiver_unit] ERROR");
    $finish;
  end

endmodule

// File: idle_timeout_frame_receiver_unit.f
+incdir+hdl
hdl/itfr_pkg.sv
hdl/itfr_ram.sv
hdl/itfr_ctrl.sv
hdl/idle_timeout_frame_receiver_unit.sv
tb/sv/tb_idle_timeout_frame_receiver_unit.sv
